// ===== src/ptd_pkg.sv =====
// Shared types and constants of the periodic task dispatcher.
package ptd_pkg;

   localparam int unsigned DEF_TASK_SLOTS = 16;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned ID_W     = 8;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned TIME_W   = 32;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [ID_W-1:0]     task_id_type;
   typedef logic [PERIOD_W-1:0] period_type;
   typedef logic [TIME_W-1:0]   ticks_type;

   localparam opcode_type OP_TICK     = 2'd0;
   localparam opcode_type OP_ADD      = 2'd1;
   localparam opcode_type OP_DELETE   = 2'd2;
   localparam opcode_type OP_DISPATCH = 2'd3;

   // One row of the task table.
   typedef struct packed {
      task_id_type id;
      period_type  period;
      ticks_type   start;
   } entry_type;

   // Verdict of the shared compare unit on the row being examined.
   typedef struct packed {
      logic due;
      logic match;
   } cmp_res_type;

   // One result word.
   typedef struct packed {
      logic        is_run;
      task_id_type run_task_id;
      logic        add_full;
      logic        last;
   } rsp_type;

endpackage

// ===== src/ptd_ifs.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface ptd_req_if;
   logic                valid;
   logic                ready;
   ptd_pkg::opcode_type  opcode;
   ptd_pkg::task_id_type task_id;
   ptd_pkg::period_type  period;

   modport source (output valid, output opcode, output task_id, output period, input ready);
   modport sink   (input valid, input opcode, input task_id, input period, output ready);
endinterface

interface ptd_rsp_if;
   logic                valid;
   logic                ready;
   logic                is_run;
   ptd_pkg::task_id_type run_task_id;
   logic                add_full;
   logic                last;

   modport source (output valid, output is_run, output run_task_id, output add_full,
                   output last, input ready);
   modport sink   (input valid, input is_run, input run_task_id, input add_full,
                   input last, output ready);
endinterface

// ===== src/ptd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptd_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/ptd_cmp.sv =====
// Shared compare unit: elapsed-time due test and id match on one table row.
module ptd_cmp (
   input  ptd_pkg::ticks_type   now_ticks,
   input  ptd_pkg::entry_type   entry,
   input  ptd_pkg::task_id_type key,
   output ptd_pkg::cmp_res_type res
);
   import ptd_pkg::*;

   ticks_type elapsed;

   // Wrapping subtraction gives the elapsed time modulo the counter range.
   assign elapsed   = now_ticks - entry.start;
   assign res.due   = elapsed >= TIME_W'(entry.period);
   assign res.match = entry.id == key;

endmodule

// ===== src/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: sequencer, time count and task table.
//
// Usage. Request words arrive on req_chan (opcode, task_id, period) and result
// words leave on rsp_chan (is_run, run_task_id, add_full, last); both sides use
// a valid/ready handshake and a word moves when valid and ready are both high.
// A tick is absorbed in the cycle it is accepted and the block is ready again
// at once. Add, delete and dispatch walk the task table one row per cycle
// through the single read port of the entry memory, save while a dispatch
// waits on a row for the output register to drain; an add then sends its
// status word from ST_RESP once the output register is free. Until the
// operation is done req_chan.ready is low. An add always answers with one
// status word; a dispatch answers with one word per due task, the final one
// carrying last, and with nothing if no task is due; tick and delete give no
// word.
// A result sits in an output register, so the next request can be taken while
// the receiver still holds off; a dispatch that finds a second due task while
// the output register is still full waits on that row until it drains.
// Reset (synchronous, active high) clears the time count, the row count and
// the handshakes. The table memory is not cleared: only rows below the count
// are ever read, and every one of those has been written.
module periodic_task_dispatcher #(
   parameter int unsigned TASK_SLOTS = ptd_pkg::DEF_TASK_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   ptd_req_if.sink   req_chan,
   ptd_rsp_if.source rsp_chan
);
   import ptd_pkg::*;

   localparam int unsigned CNT_W   = $clog2(TASK_SLOTS + 1);
   localparam int unsigned IDX_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int unsigned ENTRY_W = $bits(entry_type);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_MOVE = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]       state_ff, state_in;
   ticks_type        now_ff, now_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   opcode_type       op_ff, op_in;
   task_id_type      key_ff, key_in;
   period_type       per_ff, per_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             full_ff, full_in;
   logic             pend_valid_ff, pend_valid_in;
   task_id_type      pend_id_ff, pend_id_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             accept;
   logic             out_free;
   logic             in_range;
   logic [CNT_W-1:0] top_cnt;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_entry;
   cmp_res_type      cmp_res;

   // The table lives in one memory row per task: id, period and start stamp.
   ptd_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (TASK_SLOTS),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // The one compare unit is reused for the id search and the due test.
   ptd_cmp u_cmp (
      .now_ticks (now_ff),
      .entry     (rd_entry),
      .key       (key_ff),
      .res       (cmp_res)
   );

   assign req_chan.ready       = state_ff == ST_IDLE;
   assign accept               = req_chan.valid && req_chan.ready;
   assign out_free             = !out_valid_ff || rsp_chan.ready;
   assign in_range             = idx_ff < count_ff;
   assign top_cnt              = count_ff - CNT_W'(1);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.is_run      = out_ff.is_run;
   assign rsp_chan.run_task_id = out_ff.run_task_id;
   assign rsp_chan.add_full    = out_ff.add_full;
   assign rsp_chan.last        = out_ff.last;

   // The read address always names the row whose data is wanted next cycle,
   // so idx_ff and the memory output stay in step. While a dispatch waits on
   // the output register the same row is simply read again.
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      per_in        = per_ff;
      slot_in       = slot_ff;
      full_in       = full_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = rd_entry;
      rd_addr       = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            idx_in  = '0;
            rd_addr = '0;
            if (accept) begin
               op_in  = req_chan.opcode;
               key_in = req_chan.task_id;
               per_in = req_chan.period;
               if (req_chan.opcode == OP_TICK) begin
                  now_in = now_ff + TIME_W'(1);
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (!in_range) begin
               // Every row has been looked at.
               unique case (op_ff)
                  OP_ADD: begin
                     if (count_ff == SLOTS_CNT) begin
                        full_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = '{id: key_ff, period: per_ff, start: now_ff};
                        count_in = count_ff + CNT_W'(1);
                        full_in  = 1'b0;
                     end
                     state_in = ST_RESP;
                  end
                  OP_DISPATCH: begin
                     if (!pend_valid_ff) begin
                        state_in = ST_IDLE;
                     end else if (out_free) begin
                        out_in        = '{is_run: 1'b1, run_task_id: pend_id_ff,
                                          add_full: 1'b0, last: 1'b1};
                        out_valid_in  = 1'b1;
                        pend_valid_in = 1'b0;
                        state_in      = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end else begin
               unique case (op_ff)
                  OP_DISPATCH: begin
                     // A due id is held back one step so that the last one can
                     // be flagged once the walk is over.
                     if (!cmp_res.due) begin
                        idx_in  = idx_ff + CNT_W'(1);
                        rd_addr = idx_in[IDX_W-1:0];
                     end else if (!pend_valid_ff || out_free) begin
                        if (pend_valid_ff) begin
                           out_in       = '{is_run: 1'b1, run_task_id: pend_id_ff,
                                            add_full: 1'b0, last: 1'b0};
                           out_valid_in = 1'b1;
                        end
                        pend_valid_in = 1'b1;
                        pend_id_in    = rd_entry.id;
                        wr_en         = 1'b1;
                        wr_data       = '{id: rd_entry.id, period: rd_entry.period,
                                          start: now_ff};
                        idx_in        = idx_ff + CNT_W'(1);
                        rd_addr       = idx_in[IDX_W-1:0];
                     end
                  end
                  OP_DELETE: begin
                     if (!cmp_res.match) begin
                        idx_in  = idx_ff + CNT_W'(1);
                        rd_addr = idx_in[IDX_W-1:0];
                     end else if (idx_ff == top_cnt) begin
                        count_in = top_cnt;
                        state_in = ST_IDLE;
                     end else begin
                        // Fetch the top row; it fills the hole next cycle.
                        slot_in  = idx_ff[IDX_W-1:0];
                        rd_addr  = top_cnt[IDX_W-1:0];
                        state_in = ST_MOVE;
                     end
                  end
                  default: begin
                     if (cmp_res.match) begin
                        full_in  = 1'b0;
                        state_in = ST_RESP;
                     end else begin
                        idx_in  = idx_ff + CNT_W'(1);
                        rd_addr = idx_in[IDX_W-1:0];
                     end
                  end
               endcase
            end
         end

         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_entry;
            count_in = top_cnt;
            state_in = ST_IDLE;
         end

         ST_RESP: begin
            if (out_free) begin
               out_in       = '{is_run: 1'b0, run_task_id: '0,
                                add_full: full_ff, last: 1'b1};
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      per_ff     <= per_in;
      slot_ff    <= slot_in;
      full_ff    <= full_in;
      pend_id_ff <= pend_id_in;
      out_ff     <= out_in;
   end

   // The row count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_CNT)
      else $error("row count beyond table size");

   // The row count moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |->
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("row count jumped");

   // An accepted tick advances the time count by exactly one.
   a_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.opcode == OP_TICK) |=> now_ff == $past(now_ff) + TIME_W'(1))
      else $error("tick did not advance time");

   // A held-back run id only exists while a dispatch walk is under way.
   a_pend_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_WALK && op_ff == OP_DISPATCH))
      else $error("pending run id outside a dispatch walk");

endmodule
